// ===== rtl/wnc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the weighted n-gram counter.
package wnc_pkg;

  localparam int LETTER_W    = 5;
  localparam int OP_W        = 2;
  localparam int WEIGHT_W    = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_ALPHABET_SIZE = 26;
  localparam int DEF_COUNT_WIDTH   = 31;

  localparam logic [WEIGHT_W-1:0] PAIR_WEIGHT_RESET   = 16'd1;
  localparam logic [WEIGHT_W-1:0] TRIPLE_WEIGHT_RESET = 16'd10;
  localparam logic [WEIGHT_W-1:0] QUAD_WEIGHT_RESET   = 16'd100;

  localparam logic [1:0] FILL_FULL = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_FEED  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAIR_WEIGHT   = 2'd0,
    REG_TRIPLE_WEIGHT = 2'd1,
    REG_QUAD_WEIGHT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic pair;
    logic triple;
    logic quad;
  } gram_sel_t;

endpackage

// ===== rtl/wnc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module wnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/wnc_index.sv =====
`timescale 1ns / 1ps
// Word history and table address generation for feed and read requests.
module wnc_index import wnc_pkg::*; #(
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int PAIR_AW       = 10,
  parameter int TRIPLE_AW     = 15,
  parameter int QUAD_AW       = 19
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  op_t                  op,
  input  logic [LETTER_W-1:0]  letter,
  input  logic                 word_start,
  input  logic [LETTER_W-1:0]  first,
  input  logic [LETTER_W-1:0]  second,
  input  logic [LETTER_W-1:0]  third,
  input  logic [LETTER_W-1:0]  fourth,
  output logic [PAIR_AW-1:0]   pair_addr,
  output logic [TRIPLE_AW-1:0] triple_addr,
  output logic [QUAD_AW-1:0]   quad_addr,
  output gram_sel_t            sel
);

  localparam int MW = QUAD_AW;
  localparam logic [MW-1:0] A1 = MW'(ALPHABET_SIZE);
  localparam logic [MW-1:0] A2 = MW'(ALPHABET_SIZE * ALPHABET_SIZE);
  localparam logic [MW-1:0] A3 = MW'(ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE);
  localparam logic [LETTER_W:0] LIMIT = (LETTER_W + 1)'(ALPHABET_SIZE);

  logic [1:0]           fill;
  logic [LETTER_W-1:0]  last_letter;
  logic [PAIR_AW-1:0]   triple_prefix;
  logic [TRIPLE_AW-1:0] quad_prefix;

  logic [1:0]    fill_eff;
  logic          letter_ok;
  logic          first_ok;
  logic          second_ok;
  logic          third_ok;
  logic          fourth_ok;
  logic [MW-1:0] feed_pair;
  logic [MW-1:0] feed_triple;
  logic [MW-1:0] feed_quad;
  logic [MW-1:0] read_pair;
  logic [MW-1:0] read_triple;
  logic [MW-1:0] read_quad;

  always_comb begin
    fill_eff  = word_start ? 2'd0 : fill;
    letter_ok = {1'b0, letter} < LIMIT;
    first_ok  = {1'b0, first} < LIMIT;
    second_ok = {1'b0, second} < LIMIT;
    third_ok  = {1'b0, third} < LIMIT;
    fourth_ok = {1'b0, fourth} < LIMIT;

    feed_pair   = MW'(last_letter) * A1 + MW'(letter);
    feed_triple = MW'(triple_prefix) * A1 + MW'(letter);
    feed_quad   = MW'(quad_prefix) * A1 + MW'(letter);

    read_pair   = MW'(first) * A1 + MW'(second);
    read_triple = MW'(first) * A2 + MW'(second) * A1 + MW'(third);
    read_quad   = MW'(first) * A3 + MW'(second) * A2 + MW'(third) * A1 + MW'(fourth);

    pair_addr   = feed_pair[PAIR_AW-1:0];
    triple_addr = feed_triple[TRIPLE_AW-1:0];
    quad_addr   = feed_quad[QUAD_AW-1:0];
    sel         = '0;
    case (op)
      OP_FEED: begin
        sel.pair   = letter_ok && (fill_eff != 2'd0);
        sel.triple = letter_ok && (fill_eff inside {2'd2, FILL_FULL});
        sel.quad   = letter_ok && (fill_eff == FILL_FULL);
      end
      OP_READ: begin
        pair_addr   = read_pair[PAIR_AW-1:0];
        triple_addr = read_triple[TRIPLE_AW-1:0];
        quad_addr   = read_quad[QUAD_AW-1:0];
        sel.pair    = first_ok && second_ok;
        sel.triple  = first_ok && second_ok && third_ok;
        sel.quad    = first_ok && second_ok && third_ok && fourth_ok;
      end
      default: begin
        sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (advance && op == OP_FEED && letter_ok) begin
      fill <= (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && op == OP_FEED && letter_ok) begin
      last_letter   <= letter;
      triple_prefix <= feed_pair[PAIR_AW-1:0];
      quad_prefix   <= feed_triple[TRIPLE_AW-1:0];
    end
  end

endmodule

// ===== rtl/wnc_bump.sv =====
`timescale 1ns / 1ps
// Saturating weighted increment of one counter.
module wnc_bump import wnc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [WEIGHT_W-1:0]    weight,
  output logic [COUNT_WIDTH-1:0] count_next,
  output logic                   at_max
);

  localparam int SUM_W = ((COUNT_WIDTH > WEIGHT_W) ? COUNT_WIDTH : WEIGHT_W) + 1;
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_WIDTH{1'b1}});

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum        = SUM_W'(count) + SUM_W'(weight);
    at_max     = sum >= COUNT_MAX;
    count_next = at_max ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  end

endmodule

// ===== rtl/weighted_ngram_counter_top.sv =====
`timescale 1ns / 1ps
// Top level of the weighted letter n-gram counter.
//
// Requests arrive on the item channel (item_valid, item_stall): feed a letter,
// read the three counts of a queried four-letter prefix, or clear all tables.
// Every request yields exactly one result on the result channel
// (result_valid, result_stall). Weights are written at any time through the
// cfg channel, which is always ready.
// A feed or read request is accepted in ST_IDLE, issues the synchronous read
// of the count memories in ST_LOOKUP, and does the saturating update and
// write-back in ST_UPDATE, where it waits until the result register frees.
// The next request is taken only once the result is loaded and the state is
// back in ST_IDLE, so the block cannot start a new request before the last
// one's read, modify and write loop on the count memories is through.
// A clear request sweeps all three memories one entry per cycle, over as many
// entries as the quadgram table has (456976 at the default alphabet), then
// returns an all-zero result. The same sweep runs after reset, with item_stall
// high until it finishes.
// While the receiver stalls, the result is held; one further request may be
// accepted and waits in its update step until the result register frees.
module weighted_ngram_counter_top import wnc_pkg::*; #(
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [OP_W-1:0]        operation,
  input  logic [LETTER_W-1:0]    letter_code,
  input  logic                   word_start,
  input  logic [LETTER_W-1:0]    query_first,
  input  logic [LETTER_W-1:0]    query_second,
  input  logic [LETTER_W-1:0]    query_third,
  input  logic [LETTER_W-1:0]    query_fourth,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [COUNT_WIDTH-1:0] pair_count,
  output logic [COUNT_WIDTH-1:0] triple_count,
  output logic [COUNT_WIDTH-1:0] quad_count,
  output logic                   saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data
);

  localparam int PAIR_DEPTH   = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int TRIPLE_DEPTH = PAIR_DEPTH * ALPHABET_SIZE;
  localparam int QUAD_DEPTH   = TRIPLE_DEPTH * ALPHABET_SIZE;
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);
  localparam int TRIPLE_AW    = $clog2(TRIPLE_DEPTH);
  localparam int QUAD_AW      = $clog2(QUAD_DEPTH);
  localparam int SWEEP_W      = QUAD_AW;
  localparam logic [SWEEP_W-1:0] SWEEP_LAST   = SWEEP_W'(QUAD_DEPTH - 1);
  localparam logic [SWEEP_W-1:0] PAIR_LIMIT   = SWEEP_W'(PAIR_DEPTH);
  localparam logic [SWEEP_W-1:0] TRIPLE_LIMIT = SWEEP_W'(TRIPLE_DEPTH);

  state_t state;
  state_t state_next;

  logic [SWEEP_W-1:0]  sweep_index;
  logic                sweep_reply;
  logic [WEIGHT_W-1:0] pair_weight;
  logic [WEIGHT_W-1:0] triple_weight;
  logic [WEIGHT_W-1:0] quad_weight;

  op_t                  held_op;
  logic [LETTER_W-1:0]  held_letter;
  logic                 held_start;
  logic [LETTER_W-1:0]  held_first;
  logic [LETTER_W-1:0]  held_second;
  logic [LETTER_W-1:0]  held_third;
  logic [LETTER_W-1:0]  held_fourth;
  gram_sel_t            held_sel;
  logic [PAIR_AW-1:0]   pair_slot;
  logic [TRIPLE_AW-1:0] triple_slot;
  logic [QUAD_AW-1:0]   quad_slot;

  gram_sel_t            sel;
  logic [PAIR_AW-1:0]   pair_addr;
  logic [TRIPLE_AW-1:0] triple_addr;
  logic [QUAD_AW-1:0]   quad_addr;

  logic [COUNT_WIDTH-1:0] pair_rd;
  logic [COUNT_WIDTH-1:0] triple_rd;
  logic [COUNT_WIDTH-1:0] quad_rd;
  logic [COUNT_WIDTH-1:0] pair_new;
  logic [COUNT_WIDTH-1:0] triple_new;
  logic [COUNT_WIDTH-1:0] quad_new;
  logic                   pair_max;
  logic                   triple_max;
  logic                   quad_max;

  logic accept;
  logic out_free;
  logic sweeping;
  logic sweep_end;
  logic lookup;
  logic update_done;
  logic pair_we;
  logic triple_we;
  logic quad_we;
  logic [PAIR_AW-1:0]     pair_wr_addr;
  logic [TRIPLE_AW-1:0]   triple_wr_addr;
  logic [QUAD_AW-1:0]     quad_wr_addr;
  logic [COUNT_WIDTH-1:0] pair_wr_data;
  logic [COUNT_WIDTH-1:0] triple_wr_data;
  logic [COUNT_WIDTH-1:0] quad_wr_data;
  logic [COUNT_WIDTH-1:0] pair_result;
  logic [COUNT_WIDTH-1:0] triple_result;
  logic [COUNT_WIDTH-1:0] quad_result;
  logic                   sat_result;

  wnc_index #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .PAIR_AW       (PAIR_AW),
    .TRIPLE_AW     (TRIPLE_AW),
    .QUAD_AW       (QUAD_AW)
  ) u_index (
    .clk         (clk),
    .rst         (rst),
    .advance     (lookup),
    .op          (held_op),
    .letter      (held_letter),
    .word_start  (held_start),
    .first       (held_first),
    .second      (held_second),
    .third       (held_third),
    .fourth      (held_fourth),
    .pair_addr   (pair_addr),
    .triple_addr (triple_addr),
    .quad_addr   (quad_addr),
    .sel         (sel)
  );

  wnc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk     (clk),
    .we      (pair_we),
    .wr_addr (pair_wr_addr),
    .wr_data (pair_wr_data),
    .re      (lookup && sel.pair),
    .rd_addr (pair_addr),
    .rd_data (pair_rd)
  );

  wnc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TRIPLE_DEPTH)) u_triple_ram (
    .clk     (clk),
    .we      (triple_we),
    .wr_addr (triple_wr_addr),
    .wr_data (triple_wr_data),
    .re      (lookup && sel.triple),
    .rd_addr (triple_addr),
    .rd_data (triple_rd)
  );

  wnc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QUAD_DEPTH)) u_quad_ram (
    .clk     (clk),
    .we      (quad_we),
    .wr_addr (quad_wr_addr),
    .wr_data (quad_wr_data),
    .re      (lookup && sel.quad),
    .rd_addr (quad_addr),
    .rd_data (quad_rd)
  );

  wnc_bump #(.COUNT_WIDTH(COUNT_WIDTH)) u_pair_bump (
    .count      (pair_rd),
    .weight     (pair_weight),
    .count_next (pair_new),
    .at_max     (pair_max)
  );

  wnc_bump #(.COUNT_WIDTH(COUNT_WIDTH)) u_triple_bump (
    .count      (triple_rd),
    .weight     (triple_weight),
    .count_next (triple_new),
    .at_max     (triple_max)
  );

  wnc_bump #(.COUNT_WIDTH(COUNT_WIDTH)) u_quad_bump (
    .count      (quad_rd),
    .weight     (quad_weight),
    .count_next (quad_new),
    .at_max     (quad_max)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    accept      = 1'b0;
    sweeping    = 1'b0;
    sweep_end   = 1'b0;
    lookup      = 1'b0;
    update_done = 1'b0;
    out_free    = !result_valid || !result_stall;
    case (state)
      ST_SWEEP: begin
        sweeping  = 1'b1;
        sweep_end = sweep_index == SWEEP_LAST;
        if (sweep_end) begin
          state_next = sweep_reply ? ST_UPDATE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        accept     = item_valid;
        if (item_valid) begin
          state_next = (op_t'(operation) == OP_CLEAR) ? ST_SWEEP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        lookup     = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        update_done = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_index <= '0;
      sweep_reply <= 1'b0;
    end else if (sweeping) begin
      sweep_index <= sweep_end ? '0 : sweep_index + 1'b1;
      if (sweep_end) begin
        sweep_reply <= 1'b0;
      end
    end else if (accept && op_t'(operation) == OP_CLEAR) begin
      sweep_reply <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_weight   <= PAIR_WEIGHT_RESET;
      triple_weight <= TRIPLE_WEIGHT_RESET;
      quad_weight   <= QUAD_WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAIR_WEIGHT:   pair_weight   <= cfg_data;
        REG_TRIPLE_WEIGHT: triple_weight <= cfg_data;
        REG_QUAD_WEIGHT:   quad_weight   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op     <= op_t'(operation);
      held_letter <= letter_code;
      held_start  <= word_start;
      held_first  <= query_first;
      held_second <= query_second;
      held_third  <= query_third;
      held_fourth <= query_fourth;
    end
    if (lookup) begin
      held_sel    <= sel;
      pair_slot   <= pair_addr;
      triple_slot <= triple_addr;
      quad_slot   <= quad_addr;
    end
  end

  always_comb begin
    pair_result   = '0;
    triple_result = '0;
    quad_result   = '0;
    sat_result    = 1'b0;
    case (held_op)
      OP_FEED: begin
        pair_result   = held_sel.pair ? pair_new : '0;
        triple_result = held_sel.triple ? triple_new : '0;
        quad_result   = held_sel.quad ? quad_new : '0;
        sat_result    = (held_sel.pair && pair_max) || (held_sel.triple && triple_max)
                        || (held_sel.quad && quad_max);
      end
      OP_READ: begin
        pair_result   = held_sel.pair ? pair_rd : '0;
        triple_result = held_sel.triple ? triple_rd : '0;
        quad_result   = held_sel.quad ? quad_rd : '0;
      end
      default: begin
        sat_result = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (sweeping) begin
      pair_we        = sweep_index < PAIR_LIMIT;
      triple_we      = sweep_index < TRIPLE_LIMIT;
      quad_we        = 1'b1;
      pair_wr_addr   = sweep_index[PAIR_AW-1:0];
      triple_wr_addr = sweep_index[TRIPLE_AW-1:0];
      quad_wr_addr   = sweep_index[QUAD_AW-1:0];
      pair_wr_data   = '0;
      triple_wr_data = '0;
      quad_wr_data   = '0;
    end else begin
      pair_we        = update_done && held_op == OP_FEED && held_sel.pair;
      triple_we      = update_done && held_op == OP_FEED && held_sel.triple;
      quad_we        = update_done && held_op == OP_FEED && held_sel.quad;
      pair_wr_addr   = pair_slot;
      triple_wr_addr = triple_slot;
      quad_wr_addr   = quad_slot;
      pair_wr_data   = pair_new;
      triple_wr_data = triple_new;
      quad_wr_data   = quad_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (update_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_done) begin
      pair_count   <= pair_result;
      triple_count <= triple_result;
      quad_count   <= quad_result;
      saturated    <= sat_result;
    end
  end

endmodule

// ===== rtl/wnc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the n-gram counter and their binding to the top level.
module wnc_checker import wnc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [COUNT_WIDTH-1:0] pair_count,
  input logic [COUNT_WIDTH-1:0] triple_count,
  input logic [COUNT_WIDTH-1:0] quad_count,
  input logic                   saturated
);

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(pair_count)
      && $stable(triple_count) && $stable(quad_count) && $stable(saturated))
    else $error("Stalled result changed or was dropped.");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("A request was accepted while another was in progress.");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> pair_count == '1 || triple_count == '1
      || quad_count == '1)
    else $error("Saturation flagged without a counter at its maximum.");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> item_stall && !result_valid)
    else $error("Requests were open or a result shown right after reset.");

endmodule

bind weighted_ngram_counter_top wnc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);

// ===== test/weighted_ngram_counter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the weighted letter n-gram counter top level.
module weighted_ngram_counter_top_tb;
  import wnc_pkg::*;

  localparam int ALPHA     = DEF_ALPHABET_SIZE;
  localparam int COUNT_W   = DEF_COUNT_WIDTH;
  localparam int LIMIT     = 4000000;
  localparam int LONG_HOLD = 80;
  localparam int HEAVY_RUN = 24;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [LETTER_W-1:0]          letter;
    logic                         begins_word;
    logic [3:0][LETTER_W-1:0]     query;
  } ngram_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pair;
    logic [COUNT_W-1:0] triple;
    logic [COUNT_W-1:0] quad;
    logic               sat;
  } gram_counts_t;

  class ngram_scoreboard;
    logic [WEIGHT_W-1:0]   weight [3];
    logic [3*LETTER_W-1:0] recent;
    int                    fill;
    logic [COUNT_W-1:0]    counts [int];
    gram_counts_t          pending [$];
    int                    errors;

    function new();
      weight[REG_PAIR_WEIGHT]   = PAIR_WEIGHT_RESET;
      weight[REG_TRIPLE_WEIGHT] = TRIPLE_WEIGHT_RESET;
      weight[REG_QUAD_WEIGHT]   = QUAD_WEIGHT_RESET;
      recent = '0;
      fill   = 0;
      errors = 0;
    endfunction

    function void set_weight(cfg_reg_t idx, logic [WEIGHT_W-1:0] value);
      weight[idx] = value;
    endfunction

    function int slot(int tbl, int idx);
      return (tbl << 19) | idx;
    endfunction

    function logic [COUNT_W-1:0] peek(int tbl, int idx);
      return counts.exists(slot(tbl, idx)) ? counts[slot(tbl, idx)] : '0;
    endfunction

    function void note_request(ngram_req_t r);
      gram_counts_t       e;
      logic [COUNT_W-1:0] grams [3];
      logic [COUNT_W:0]   sum;
      int                 idx [3];
      int                 p1, p2, p3, lt, i2, i3;
      e = '0;
      grams = '{default: '0};
      lt = int'(r.letter);
      if (r.op == OP_FEED && lt < ALPHA) begin
        if (r.begins_word) begin
          fill   = 0;
          recent = '0;
        end
        p1 = int'(recent[4:0]);
        p2 = int'(recent[9:5]);
        p3 = int'(recent[14:10]);
        idx[0] = p1 * ALPHA + lt;
        idx[1] = (p2 * ALPHA + p1) * ALPHA + lt;
        idx[2] = ((p3 * ALPHA + p2) * ALPHA + p1) * ALPHA + lt;
        for (int k = 0; k < 3; k++) begin
          if (fill > k) begin
            sum = {1'b0, peek(k, idx[k])} + weight[k];
            if (sum >= {1'b0, CNT_MAX}) begin
              sum   = {1'b0, CNT_MAX};
              e.sat = 1'b1;
            end
            counts[slot(k, idx[k])] = sum[COUNT_W-1:0];
            grams[k] = sum[COUNT_W-1:0];
          end
        end
        recent = {recent[2*LETTER_W-1:0], r.letter};
        if (fill < 3) fill++;
      end else if (r.op == OP_READ) begin
        if (int'(r.query[0]) < ALPHA && int'(r.query[1]) < ALPHA) begin
          i2 = int'(r.query[0]) * ALPHA + int'(r.query[1]);
          grams[0] = peek(0, i2);
          if (int'(r.query[2]) < ALPHA) begin
            i3 = i2 * ALPHA + int'(r.query[2]);
            grams[1] = peek(1, i3);
            if (int'(r.query[3]) < ALPHA)
              grams[2] = peek(2, i3 * ALPHA + int'(r.query[3]));
          end
        end
      end else if (r.op == OP_CLEAR) begin
        counts.delete();
      end
      e.pair   = grams[0];
      e.triple = grams[1];
      e.quad   = grams[2];
      pending.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(gram_counts_t got);
      gram_counts_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d %0d %0d %0d with no request outstanding",
                         got.pair, got.triple, got.quad, got.sat));
        return;
      end
      want = pending.pop_front();
      if (got.pair !== want.pair)
        report($sformatf("pair_count %0d, expected %0d", got.pair, want.pair));
      if (got.triple !== want.triple)
        report($sformatf("triple_count %0d, expected %0d", got.triple, want.triple));
      if (got.quad !== want.quad)
        report($sformatf("quad_count %0d, expected %0d", got.quad, want.quad));
      if (got.sat !== want.sat)
        report($sformatf("saturated %0d, expected %0d", got.sat, want.sat));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [OP_W-1:0]        operation = OP_FEED;
  logic [LETTER_W-1:0]    letter_code = '0;
  logic                   word_start = 1'b0;
  logic [LETTER_W-1:0]    query_first = '0;
  logic [LETTER_W-1:0]    query_second = '0;
  logic [LETTER_W-1:0]    query_third = '0;
  logic [LETTER_W-1:0]    query_fourth = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [COUNT_W-1:0]     pair_count;
  logic [COUNT_W-1:0]     triple_count;
  logic [COUNT_W-1:0]     quad_count;
  logic                   saturated;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]    cfg_data = '0;

  ngram_scoreboard sb = new();

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;

  weighted_ngram_counter_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .letter_code  (letter_code),
    .word_start   (word_start),
    .query_first  (query_first),
    .query_second (query_second),
    .query_third  (query_third),
    .query_fourth (query_fourth),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pair_count   (pair_count),
    .triple_count (triple_count),
    .quad_count   (quad_count),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        sb.check_result({pair_count, triple_count, quad_count, saturated});
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(0, 9);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic ngram_req_t any_req();
    ngram_req_t r;
    r.op          = OP_FEED;
    r.letter      = LETTER_W'($urandom_range(0, 31));
    r.begins_word = 1'($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) r.query[i] = LETTER_W'($urandom_range(0, 31));
    return r;
  endfunction

  function automatic ngram_req_t feed_req(int letter, bit begins);
    ngram_req_t r;
    r = any_req();
    r.letter      = LETTER_W'(letter);
    r.begins_word = begins;
    return r;
  endfunction

  function automatic ngram_req_t read_req(int a, int b, int c, int d);
    ngram_req_t r;
    r = any_req();
    r.op = OP_READ;
    r.query[0] = LETTER_W'(a);
    r.query[1] = LETTER_W'(b);
    r.query[2] = LETTER_W'(c);
    r.query[3] = LETTER_W'(d);
    return r;
  endfunction

  function automatic ngram_req_t bare_req(logic [OP_W-1:0] op);
    ngram_req_t r;
    r = any_req();
    r.op = op;
    return r;
  endfunction

  function automatic int query_letter(int span);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, span - 1);
  endfunction

  task automatic offer(input ngram_req_t r);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= r.op;
    letter_code  <= r.letter;
    word_start   <= r.begins_word;
    query_first  <= r.query[0];
    query_second <= r.query[1];
    query_third  <= r.query[2];
    query_fourth <= r.query[3];
    do @(posedge clk); while (item_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WEIGHT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_weight(idx, value);
  endtask

  task automatic set_weights(input logic [WEIGHT_W-1:0] pw, tw, qw);
    write_reg(REG_PAIR_WEIGHT, pw);
    write_reg(REG_TRIPLE_WEIGHT, tw);
    write_reg(REG_QUAD_WEIGHT, qw);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int items, input int span);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 9);
        for (int j = 0; j < len; j++)
          offer(feed_req($urandom_range(0, span - 1), j == 0));
        sent += len;
      end else if (pick < 82) begin
        offer(read_req(query_letter(span), query_letter(span),
                       query_letter(span), query_letter(span)));
        sent++;
      end else if (pick < 90) begin
        offer(feed_req($urandom_range(0, ALPHA - 1), 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 96) begin
        offer(feed_req($urandom_range(ALPHA, 31), 1'($urandom_range(0, 1))));
      end else begin
        offer(bare_req(OP_UNUSED));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_gap_pct = 25;
    rx_stall_pct <= 25;

    offer(feed_req(0, 1'b1));
    offer(feed_req(25, 1'b0));
    offer(feed_req(31, 1'b0));
    offer(feed_req(26, 1'b1));
    offer(feed_req(25, 1'b0));
    offer(feed_req(0, 1'b0));
    offer(feed_req(1, 1'b0));
    offer(feed_req(25, 1'b0));
    offer(read_req(0, 25, 25, 0));
    offer(read_req(25, 25, 0, 1));
    offer(read_req(0, 0, 0, 0));
    offer(read_req(25, 25, 25, 25));
    offer(read_req(31, 25, 25, 0));
    offer(read_req(0, 30, 25, 0));
    offer(read_req(0, 25, 26, 0));
    offer(read_req(0, 25, 25, 31));
    offer(feed_req(25, 1'b1));
    offer(feed_req(25, 1'b0));
    offer(bare_req(OP_UNUSED));
    offer(read_req(25, 25, 0, 0));

    drain();
    set_weights('1, '1, '1);
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    offer(feed_req(2, 1'b1));
    repeat (HEAVY_RUN) offer(feed_req(2, 1'b0));
    offer(read_req(2, 2, 2, 2));
    drain();
    set_weights('0, '0, '0);
    tx_gap_pct = 25;
    rx_stall_pct <= 25;
    offer(feed_req(2, 1'b0));
    offer(read_req(2, 2, 2, 2));
    offer(bare_req(OP_CLEAR));
    offer(feed_req(2, 1'b0));
    offer(read_req(2, 2, 2, 2));
    offer(read_req(25, 25, 0, 1));

    drain();
    set_weights(WEIGHT_W'($urandom_range(0, 65535)), WEIGHT_W'($urandom_range(0, 65535)),
                WEIGHT_W'($urandom_range(0, 65535)));
    tx_gap_pct = 0;
    hold_asks <= hold_asks + 1;
    random_phase(40, 4);
    tx_gap_pct = 30;
    rx_stall_pct <= 30;
    random_phase(230, 4);

    drain();
    set_weights('0, '0, '0);
    random_phase(270, ALPHA);

    drain();
    set_weights('1, '0, '1);
    set_weights(16'hFFFF, WEIGHT_W'($urandom_range(0, 65535)), 16'd7);
    tx_gap_pct = 15;
    rx_stall_pct <= 40;
    random_phase(270, 3);

    drain();
    set_weights(WEIGHT_W'($urandom_range(0, 65535)), WEIGHT_W'($urandom_range(0, 65535)),
                WEIGHT_W'($urandom_range(0, 65535)));
    tx_gap_pct = 40;
    rx_stall_pct <= 10;
    random_phase(270, 6);

    drain();
    set_weights(PAIR_WEIGHT_RESET, TRIPLE_WEIGHT_RESET, QUAD_WEIGHT_RESET);
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    random_phase(270, 4);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wnc_pkg.sv
rtl/wnc_ram.sv
rtl/wnc_index.sv
rtl/wnc_bump.sv
rtl/weighted_ngram_counter_top.sv
rtl/wnc_checker.sv
test/weighted_ngram_counter_top_tb.sv
